[rtl/cif_pkg.sv]
// ----------------------------------------------------------------------------
// cif_pkg
// Types, constants, saturation helper and the sequencer step table of the
// impedance wrench block.
// ----------------------------------------------------------------------------
package cif_pkg;

    localparam int VW     = 32;               // value word
    localparam int FW     = 16;               // fraction bits
    localparam int CW     = 10;               // gain register width
    localparam int OP_W   = 2;
    localparam int CIDX_W = 3;
    localparam int WIDE_W = VW + CW + 2;      // accumulators
    localparam int STEP_W = 6;

    localparam logic [OP_W-1:0] OP_TARGET  = 2'd0;
    localparam logic [OP_W-1:0] OP_CURRENT = 2'd1;
    localparam logic [OP_W-1:0] OP_TWIST   = 2'd2;

    localparam logic [CIDX_W-1:0] REG_STIFF_LIN = 3'd0;
    localparam logic [CIDX_W-1:0] REG_STIFF_ANG = 3'd1;
    localparam logic [CIDX_W-1:0] REG_DAMP_LXY  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DAMP_LZ   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_DAMP_AXY  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_DAMP_AZ   = 3'd5;

    localparam logic [CW-1:0] RST_STIFF_LIN = CW'(100);
    localparam logic [CW-1:0] RST_STIFF_ANG = CW'(150);
    localparam logic [CW-1:0] RST_DAMP_XY   = CW'(90);
    localparam logic [CW-1:0] RST_DAMP_Z    = CW'(60);

    localparam logic signed [WIDE_W-1:0] VMAX_WD = WIDE_W'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] VMIN_WD = -VMAX_WD - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] ONE_WD  = WIDE_W'(64'sd1 <<< FW);
    localparam logic signed [VW-1:0]     VMAX_V  = VMAX_WD[VW-1:0];
    localparam logic signed [VW-1:0]     VMIN_V  = VMIN_WD[VW-1:0];
    localparam logic signed [VW-1:0]     ONE_V   = ONE_WD[VW-1:0];

    // quaternion component slots
    localparam logic [1:0] QX = 2'd0;
    localparam logic [1:0] QY = 2'd1;
    localparam logic [1:0] QZ = 2'd2;
    localparam logic [1:0] QW = 2'd3;

    localparam logic [STEP_W-1:0] CMP_STEP  = STEP_W'(16);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(43);

    typedef enum logic [3:0] {
        S_IDLE, S_OPND, S_PROD, S_ACC, S_FLIP, S_WK, S_WB, S_DONE
    } t_state;

    typedef enum logic [1:0] {A_CUR, A_E3, A_RMAT} t_asrc;
    typedef enum logic [1:0] {B_TGT, B_ERR, B_CUR} t_bsrc;
    typedef enum logic [1:0] {M_SUM, M_DBL, M_OMD, M_CMP} t_mode;
    typedef enum logic [1:0] {D_ERR, D_RMAT, D_ORI, D_FLAG} t_dkind;

    typedef struct packed {
        t_asrc      a_src;
        logic [3:0] a_idx;
        t_bsrc      b_src;
        logic [1:0] b_idx;
        logic       neg;
        logic       first;
        logic       last;
        t_mode      mode;
        t_dkind     dkind;
        logic [3:0] didx;
    } t_step;

    function automatic logic signed [VW-1:0] sat_w(input logic signed [WIDE_W-1:0] v);
        if (v > VMAX_WD) begin
            return VMAX_V;
        end else if (v < VMIN_WD) begin
            return VMIN_V;
        end
        return v[VW-1:0];
    endfunction

    function automatic t_step mk(input t_asrc as, input logic [3:0] ai, input t_bsrc bs,
                                 input logic [1:0] bi, input logic ng, input logic fs,
                                 input logic ls, input t_mode md, input t_dkind dk,
                                 input logic [3:0] di);
        t_step s;
        s.a_src = as; s.a_idx = ai; s.b_src = bs; s.b_idx = bi;
        s.neg = ng; s.first = fs; s.last = ls; s.mode = md; s.dkind = dk; s.didx = di;
        return s;
    endfunction

    function automatic logic [3:0] cq(input logic [1:0] q);
        return {2'b00, q};
    endfunction

    // error quaternion, w test, rotation matrix, rotated error
    function automatic t_step step_rom(input logic [STEP_W-1:0] s);
        case (s)
            6'd0:  return mk(A_CUR, cq(QW), B_TGT, QW, 1'b0, 1'b1, 1'b0, M_SUM, D_ERR, 4'd3);
            6'd1:  return mk(A_CUR, cq(QX), B_TGT, QX, 1'b0, 1'b0, 1'b0, M_SUM, D_ERR, 4'd3);
            6'd2:  return mk(A_CUR, cq(QY), B_TGT, QY, 1'b0, 1'b0, 1'b0, M_SUM, D_ERR, 4'd3);
            6'd3:  return mk(A_CUR, cq(QZ), B_TGT, QZ, 1'b0, 1'b0, 1'b1, M_SUM, D_ERR, 4'd3);
            6'd4:  return mk(A_CUR, cq(QW), B_TGT, QX, 1'b0, 1'b1, 1'b0, M_SUM, D_ERR, 4'd0);
            6'd5:  return mk(A_CUR, cq(QX), B_TGT, QW, 1'b1, 1'b0, 1'b0, M_SUM, D_ERR, 4'd0);
            6'd6:  return mk(A_CUR, cq(QY), B_TGT, QZ, 1'b1, 1'b0, 1'b0, M_SUM, D_ERR, 4'd0);
            6'd7:  return mk(A_CUR, cq(QZ), B_TGT, QY, 1'b0, 1'b0, 1'b1, M_SUM, D_ERR, 4'd0);
            6'd8:  return mk(A_CUR, cq(QW), B_TGT, QY, 1'b0, 1'b1, 1'b0, M_SUM, D_ERR, 4'd1);
            6'd9:  return mk(A_CUR, cq(QY), B_TGT, QW, 1'b1, 1'b0, 1'b0, M_SUM, D_ERR, 4'd1);
            6'd10: return mk(A_CUR, cq(QZ), B_TGT, QX, 1'b1, 1'b0, 1'b0, M_SUM, D_ERR, 4'd1);
            6'd11: return mk(A_CUR, cq(QX), B_TGT, QZ, 1'b0, 1'b0, 1'b1, M_SUM, D_ERR, 4'd1);
            6'd12: return mk(A_CUR, cq(QW), B_TGT, QZ, 1'b0, 1'b1, 1'b0, M_SUM, D_ERR, 4'd2);
            6'd13: return mk(A_CUR, cq(QZ), B_TGT, QW, 1'b1, 1'b0, 1'b0, M_SUM, D_ERR, 4'd2);
            6'd14: return mk(A_CUR, cq(QX), B_TGT, QY, 1'b1, 1'b0, 1'b0, M_SUM, D_ERR, 4'd2);
            6'd15: return mk(A_CUR, cq(QY), B_TGT, QX, 1'b0, 1'b0, 1'b1, M_SUM, D_ERR, 4'd2);
            6'd16: return mk(A_E3,  4'd0,   B_ERR, QW, 1'b0, 1'b1, 1'b1, M_CMP, D_FLAG, 4'd0);
            6'd17: return mk(A_CUR, cq(QY), B_CUR, QY, 1'b0, 1'b1, 1'b0, M_OMD, D_RMAT, 4'd0);
            6'd18: return mk(A_CUR, cq(QZ), B_CUR, QZ, 1'b0, 1'b0, 1'b1, M_OMD, D_RMAT, 4'd0);
            6'd19: return mk(A_CUR, cq(QX), B_CUR, QY, 1'b0, 1'b1, 1'b0, M_DBL, D_RMAT, 4'd1);
            6'd20: return mk(A_CUR, cq(QW), B_CUR, QZ, 1'b1, 1'b0, 1'b1, M_DBL, D_RMAT, 4'd1);
            6'd21: return mk(A_CUR, cq(QX), B_CUR, QZ, 1'b0, 1'b1, 1'b0, M_DBL, D_RMAT, 4'd2);
            6'd22: return mk(A_CUR, cq(QW), B_CUR, QY, 1'b0, 1'b0, 1'b1, M_DBL, D_RMAT, 4'd2);
            6'd23: return mk(A_CUR, cq(QX), B_CUR, QY, 1'b0, 1'b1, 1'b0, M_DBL, D_RMAT, 4'd3);
            6'd24: return mk(A_CUR, cq(QW), B_CUR, QZ, 1'b0, 1'b0, 1'b1, M_DBL, D_RMAT, 4'd3);
            6'd25: return mk(A_CUR, cq(QX), B_CUR, QX, 1'b0, 1'b1, 1'b0, M_OMD, D_RMAT, 4'd4);
            6'd26: return mk(A_CUR, cq(QZ), B_CUR, QZ, 1'b0, 1'b0, 1'b1, M_OMD, D_RMAT, 4'd4);
            6'd27: return mk(A_CUR, cq(QY), B_CUR, QZ, 1'b0, 1'b1, 1'b0, M_DBL, D_RMAT, 4'd5);
            6'd28: return mk(A_CUR, cq(QW), B_CUR, QX, 1'b1, 1'b0, 1'b1, M_DBL, D_RMAT, 4'd5);
            6'd29: return mk(A_CUR, cq(QX), B_CUR, QZ, 1'b0, 1'b1, 1'b0, M_DBL, D_RMAT, 4'd6);
            6'd30: return mk(A_CUR, cq(QW), B_CUR, QY, 1'b1, 1'b0, 1'b1, M_DBL, D_RMAT, 4'd6);
            6'd31: return mk(A_CUR, cq(QY), B_CUR, QZ, 1'b0, 1'b1, 1'b0, M_DBL, D_RMAT, 4'd7);
            6'd32: return mk(A_CUR, cq(QW), B_CUR, QX, 1'b0, 1'b0, 1'b1, M_DBL, D_RMAT, 4'd7);
            6'd33: return mk(A_CUR, cq(QX), B_CUR, QX, 1'b0, 1'b1, 1'b0, M_OMD, D_RMAT, 4'd8);
            6'd34: return mk(A_CUR, cq(QY), B_CUR, QY, 1'b0, 1'b0, 1'b1, M_OMD, D_RMAT, 4'd8);
            6'd35: return mk(A_RMAT, 4'd0,  B_ERR, 2'd0, 1'b0, 1'b1, 1'b0, M_SUM, D_ORI, 4'd0);
            6'd36: return mk(A_RMAT, 4'd1,  B_ERR, 2'd1, 1'b0, 1'b0, 1'b0, M_SUM, D_ORI, 4'd0);
            6'd37: return mk(A_RMAT, 4'd2,  B_ERR, 2'd2, 1'b0, 1'b0, 1'b1, M_SUM, D_ORI, 4'd0);
            6'd38: return mk(A_RMAT, 4'd3,  B_ERR, 2'd0, 1'b0, 1'b1, 1'b0, M_SUM, D_ORI, 4'd1);
            6'd39: return mk(A_RMAT, 4'd4,  B_ERR, 2'd1, 1'b0, 1'b0, 1'b0, M_SUM, D_ORI, 4'd1);
            6'd40: return mk(A_RMAT, 4'd5,  B_ERR, 2'd2, 1'b0, 1'b0, 1'b1, M_SUM, D_ORI, 4'd1);
            6'd41: return mk(A_RMAT, 4'd6,  B_ERR, 2'd0, 1'b0, 1'b1, 1'b0, M_SUM, D_ORI, 4'd2);
            6'd42: return mk(A_RMAT, 4'd7,  B_ERR, 2'd1, 1'b0, 1'b0, 1'b0, M_SUM, D_ORI, 4'd2);
            6'd43: return mk(A_RMAT, 4'd8,  B_ERR, 2'd2, 1'b0, 1'b0, 1'b1, M_SUM, D_ORI, 4'd2);
            default: return mk(A_CUR, 4'd0, B_TGT, 2'd0, 1'b0, 1'b1, 1'b0, M_SUM, D_FLAG, 4'd0);
        endcase
    endfunction

endpackage

[rtl/cif_if.sv]
// ----------------------------------------------------------------------------
// cif_if
// Request channels of the impedance wrench block: pose/twist in, wrench out,
// gain register writes.
// ----------------------------------------------------------------------------
interface cif_pose_if;
    import cif_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic signed [VW-1:0]   val_x;
    logic signed [VW-1:0]   val_y;
    logic signed [VW-1:0]   val_z;
    logic signed [VW-1:0]   rot_x;
    logic signed [VW-1:0]   rot_y;
    logic signed [VW-1:0]   rot_z;
    logic signed [VW-1:0]   rot_w;
    modport source (output valid, op, val_x, val_y, val_z, rot_x, rot_y, rot_z, rot_w,
                    input ready);
    modport sink   (input valid, op, val_x, val_y, val_z, rot_x, rot_y, rot_z, rot_w,
                    output ready);
endinterface

interface cif_wrench_if;
    import cif_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [VW-1:0]   force_x;
    logic signed [VW-1:0]   force_y;
    logic signed [VW-1:0]   force_z;
    logic signed [VW-1:0]   torque_x;
    logic signed [VW-1:0]   torque_y;
    logic signed [VW-1:0]   torque_z;
    modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    input ready);
    modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    output ready);
endinterface

interface cif_cfg_if;
    import cif_pkg::*;
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CW-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/cartesian_impedance_force_unit.sv]
// Target pose: stored on acceptance. Current pose: 44 steps of operand, product, accumulate
// on the single shared fixed-point multiplier, with an error sign flip after the w test.
// Twist: 6 axes, stiffness then damping product (one gain multiplier), to the wrench register.
// Throughput: one request at a time; the next request is taken on return to idle.
// Reset (synchronous, active low): gains to defaults, positions and orientation error cleared,
// target quaternion to identity, no wrench pending.
// ----------------------------------------------------------------------------
// cartesian_impedance_force_unit
// Impedance wrench from target/current pose and twist, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module cartesian_impedance_force_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    cif_cfg_if.sink             i_cfg,
    cif_pose_if.sink            i_pose,
    cif_wrench_if.source        o_wrench
);
    import cif_pkg::*;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [2:0]        r_axis;

    logic [CW-1:0] r_k_lin, r_k_ang, r_b_lxy, r_b_lz, r_b_axy, r_b_az;

    logic signed [VW-1:0] r_tp [3];
    logic signed [VW-1:0] r_tq [4];
    logic signed [VW-1:0] r_cp [3];
    logic signed [VW-1:0] r_ori [3];
    logic signed [VW-1:0] r_qa [4];
    logic signed [VW-1:0] r_qb [4];
    logic signed [VW-1:0] r_err [4];
    logic signed [VW-1:0] r_rmat [9];
    logic signed [VW-1:0] r_vel [6];
    logic signed [VW-1:0] r_wres [6];
    logic signed [VW-1:0] r_out [6];
    logic                 r_ovalid;
    logic                 r_wflag;

    logic signed [VW-1:0]     r_opa, r_opb;
    logic [VW-1:0]            mag_a, mag_b;
    logic [2*VW-1:0]          r_prod;
    logic                     r_pneg;
    logic signed [WIDE_W-1:0] r_acc;
    logic signed [WIDE_W-1:0] r_wacc;

    t_step st;
    logic  pose_acc;
    logic  done_go;

    assign st       = step_rom(r_step);
    assign pose_acc = i_pose.valid && i_pose.ready;
    assign done_go  = (r_state == S_DONE) && !r_ovalid;

    assign mag_a = r_opa[VW-1] ? -r_opa : r_opa;
    assign mag_b = r_opb[VW-1] ? -r_opb : r_opb;

    assign i_pose.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_wrench.valid    = r_ovalid;
    assign o_wrench.force_x  = r_out[0];
    assign o_wrench.force_y  = r_out[1];
    assign o_wrench.force_z  = r_out[2];
    assign o_wrench.torque_x = r_out[3];
    assign o_wrench.torque_y = r_out[4];
    assign o_wrench.torque_z = r_out[5];

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (pose_acc && i_pose.op == OP_CURRENT) begin
                    n_state = S_OPND;
                end else if (pose_acc && i_pose.op == OP_TWIST) begin
                    n_state = S_WK;
                end
            end
            S_OPND: n_state = S_PROD;
            S_PROD: n_state = S_ACC;
            S_ACC: begin
                if (r_step == CMP_STEP) begin
                    n_state = S_FLIP;
                end else if (r_step == LAST_STEP) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OPND;
                end
            end
            S_FLIP: n_state = S_OPND;
            S_WK:   n_state = S_WB;
            S_WB:   n_state = (r_axis == 3'd5) ? S_DONE : S_WK;
            S_DONE: n_state = r_ovalid ? S_DONE : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_lin <= RST_STIFF_LIN;
            r_k_ang <= RST_STIFF_ANG;
            r_b_lxy <= RST_DAMP_XY;
            r_b_lz  <= RST_DAMP_Z;
            r_b_axy <= RST_DAMP_XY;
            r_b_az  <= RST_DAMP_Z;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STIFF_LIN: r_k_lin <= i_cfg.data;
                REG_STIFF_ANG: r_k_ang <= i_cfg.data;
                REG_DAMP_LXY:  r_b_lxy <= i_cfg.data;
                REG_DAMP_LZ:   r_b_lz  <= i_cfg.data;
                REG_DAMP_AXY:  r_b_axy <= i_cfg.data;
                REG_DAMP_AZ:   r_b_az  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // fixed-point product: round half away from zero, saturate
    logic [2*VW-FW-1:0]       qf;
    logic [VW-1:0]            qr;
    logic signed [VW-1:0]     fm;
    logic signed [WIDE_W-1:0] term, acc_sum;
    logic signed [VW-1:0]     s_acc, s_dbl, s_omd;

    always_comb begin
        qf = r_prod[2*VW-1:FW];
        qr = {1'b0, qf[VW-2:0]} + VW'(r_prod[FW-1]);
        if (|qf[2*VW-FW-1:VW-1]) begin
            fm = r_pneg ? VMIN_V : VMAX_V;
        end else if (r_pneg) begin
            fm = -qr;
        end else if (qr[VW-1]) begin
            fm = VMAX_V;
        end else begin
            fm = qr;
        end
        term    = st.neg ? -WIDE_W'(fm) : WIDE_W'(fm);
        acc_sum = (st.first ? '0 : r_acc) + term;
        s_acc   = sat_w(acc_sum);
        s_dbl   = sat_w(WIDE_W'(s_acc) <<< 1);
        s_omd   = sat_w(ONE_WD - WIDE_W'(s_dbl));
    end

    // sign rule on the error quaternion
    logic [VW-1:0] m0, m1, m2, msel;
    logic          sel_neg, flip;
    always_comb begin
        m0 = r_err[0][VW-1] ? -r_err[0] : r_err[0];
        m1 = r_err[1][VW-1] ? -r_err[1] : r_err[1];
        m2 = r_err[2][VW-1] ? -r_err[2] : r_err[2];
        msel    = m0;
        sel_neg = r_err[0][VW-1];
        if (m1 > msel) begin
            msel    = m1;
            sel_neg = r_err[1][VW-1];
        end
        if (m2 > msel) begin
            sel_neg = r_err[2][VW-1];
        end
        flip = r_wflag ? r_err[3][VW-1] : sel_neg;
    end

    // wrench axis
    logic signed [VW-1:0]       w_err, w_vel;
    logic [CW-1:0]              w_k, w_b;
    logic signed [CW:0]         w_g;
    logic signed [CW+VW:0]      w_mul;
    always_comb begin
        w_vel = r_vel[r_axis];
        case (r_axis)
            3'd0, 3'd1, 3'd2: w_err = sat_w(WIDE_W'(r_tp[r_axis[1:0]]) -
                                            WIDE_W'(r_cp[r_axis[1:0]]));
            3'd3:    w_err = r_ori[0];
            3'd4:    w_err = r_ori[1];
            default: w_err = r_ori[2];
        endcase
        w_k = (r_axis < 3'd3) ? r_k_lin : r_k_ang;
        case (r_axis)
            3'd0, 3'd1: w_b = r_b_lxy;
            3'd2:       w_b = r_b_lz;
            3'd3, 3'd4: w_b = r_b_axy;
            default:    w_b = r_b_az;
        endcase
        w_g   = (r_state == S_WK) ? $signed({1'b0, w_k}) : $signed({1'b0, w_b});
        w_mul = w_g * ((r_state == S_WK) ? w_err : w_vel);
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp     <= '{default: '0};
            r_cp     <= '{default: '0};
            r_ori    <= '{default: '0};
            r_tq     <= '{'0, '0, '0, ONE_V};
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_axis   <= '0;
        end else begin
            if (r_ovalid && o_wrench.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pose_acc) begin
                        case (i_pose.op)
                            OP_TARGET: begin
                                r_tp <= '{i_pose.val_x, i_pose.val_y, i_pose.val_z};
                                r_tq <= '{i_pose.rot_x, i_pose.rot_y, i_pose.rot_z,
                                          i_pose.rot_w};
                            end
                            OP_CURRENT: begin
                                r_cp <= '{i_pose.val_x, i_pose.val_y, i_pose.val_z};
                                r_qa <= '{i_pose.rot_x, i_pose.rot_y, i_pose.rot_z,
                                          i_pose.rot_w};
                                r_qb <= '{i_pose.rot_x, i_pose.rot_y, i_pose.rot_z,
                                          i_pose.rot_w};
                                r_step <= '0;
                            end
                            OP_TWIST: begin
                                r_vel <= '{i_pose.val_x, i_pose.val_y, i_pose.val_z,
                                           i_pose.rot_x, i_pose.rot_y, i_pose.rot_z};
                                r_axis <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OPND: begin
                    case (st.a_src)
                        A_CUR:   r_opa <= r_qa[st.a_idx[1:0]];
                        A_E3:    r_opa <= r_err[3];
                        default: r_opa <= r_rmat[st.a_idx];
                    endcase
                    case (st.b_src)
                        B_TGT:   r_opb <= r_tq[st.b_idx];
                        B_ERR:   r_opb <= r_err[st.b_idx];
                        default: r_opb <= r_qb[st.b_idx];
                    endcase
                end
                S_PROD: begin
                    r_prod <= (2*VW)'(mag_a) * (2*VW)'(mag_b);
                    r_pneg <= r_opa[VW-1] ^ r_opb[VW-1];
                end
                S_ACC: begin
                    r_acc <= acc_sum;
                    if (st.last) begin
                        case (st.dkind)
                            D_ERR:  r_err[st.didx[1:0]] <= s_acc;
                            D_RMAT: r_rmat[st.didx] <= (st.mode == M_OMD) ? s_omd : s_dbl;
                            D_ORI:  r_ori[st.didx[1:0]] <= s_acc;
                            default: r_wflag <= (WIDE_W'(fm) <<< 2) > ONE_WD;
                        endcase
                    end
                    if (r_step != CMP_STEP) begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_FLIP: begin
                    if (flip) begin
                        for (int i = 0; i < 4; i++) begin
                            r_err[i] <= sat_w(-WIDE_W'(r_err[i]));
                        end
                    end
                    r_step <= r_step + STEP_W'(1);
                end
                S_WK: r_wacc <= WIDE_W'(w_mul);
                S_WB: begin
                    r_wres[r_axis] <= sat_w(r_wacc - WIDE_W'(w_mul));
                    r_axis <= r_axis + 3'd1;
                end
                S_DONE: begin
                    if (done_go) begin
                        r_out    <= r_wres;
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[verif/tb_cartesian_impedance_force_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_impedance_force_unit
// Self-checking bench for the impedance wrench unit. A driver feeds pose and
// twist requests with random gaps and a monitor stalls the wrench channel at
// random. Each accepted request goes through a local fixed-point model of the
// error quaternion, rotation and gain stage; every wrench is checked field by
// field against the oldest prediction. Gains are rewritten between phases
// once the unit is idle.
// ----------------------------------------------------------------------------
module tb_cartesian_impedance_force_unit;
    import cif_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [CIDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam longint QMAX  = 64'sd2147483647;
    localparam longint QMIN  = -64'sd2147483648;
    localparam longint QONE  = 64'sd65536;
    localparam int     SETTLE = 200;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [VW-1:0]   f[7];
    } pose_req_t;

    typedef struct {
        logic [VW-1:0] w[6];
    } wrench_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cif_cfg_if    cfg_bus();
    cif_pose_if   pose_bus();
    cif_wrench_if wrench_bus();

    cartesian_impedance_force_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus.sink),
        .i_pose   (pose_bus.sink),
        .o_wrench (wrench_bus.source)
    );

    always #6 i_clk = ~i_clk;

    pose_req_t pending_poses[$];
    wrench_t   expected_wrenches[$];
    int        mismatches = 0;
    bit        no_idle = 1'b0;

    longint gain[6];
    longint tgt_pos[3];
    longint tgt_q[4];
    longint cur_pos[3];
    longint ori_err[3];

    function automatic longint satv(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // rounded Q16.16 product, ties away from zero, saturated
    function automatic longint mulq(longint a, longint b);
        longint unsigned ua, ub, p, q;
        bit neg;
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        neg = (a < 0) != (b < 0);
        p = ua * ub;
        q = p >> FW;
        if (q >= 64'h8000_0000) return neg ? QMIN : QMAX;
        q += (p >> (FW - 1)) & 64'd1;
        if (neg) return -longint'(q);
        if (q > QMAX) return QMAX;
        return longint'(q);
    endfunction

    function automatic longint absv(longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic void form_orient_error(longint x, longint y, longint z, longint w);
        longint dx, dy, dz, dw;
        longint e[4];
        longint r[3][3];
        int sel;
        bit flip;
        dx = tgt_q[0]; dy = tgt_q[1]; dz = tgt_q[2]; dw = tgt_q[3];
        e[3] = satv(mulq(w, dw) + mulq(x, dx) + mulq(y, dy) + mulq(z, dz));
        e[0] = satv(mulq(w, dx) - mulq(dw, x) - mulq(y, dz) + mulq(z, dy));
        e[1] = satv(mulq(w, dy) - mulq(dw, y) - mulq(z, dx) + mulq(x, dz));
        e[2] = satv(mulq(w, dz) - mulq(dw, z) - mulq(x, dy) + mulq(y, dx));
        if (4 * mulq(e[3], e[3]) > QONE) begin
            flip = e[3] < 0;
        end else begin
            sel = 0;
            if (absv(e[1]) > absv(e[sel])) sel = 1;
            if (absv(e[2]) > absv(e[sel])) sel = 2;
            flip = e[sel] < 0;
        end
        if (flip) begin
            for (int i = 0; i < 4; i++) e[i] = satv(-e[i]);
        end
        r[0][0] = satv(QONE - satv(2 * satv(mulq(y, y) + mulq(z, z))));
        r[0][1] = satv(2 * satv(mulq(x, y) - mulq(w, z)));
        r[0][2] = satv(2 * satv(mulq(x, z) + mulq(w, y)));
        r[1][0] = satv(2 * satv(mulq(x, y) + mulq(w, z)));
        r[1][1] = satv(QONE - satv(2 * satv(mulq(x, x) + mulq(z, z))));
        r[1][2] = satv(2 * satv(mulq(y, z) - mulq(w, x)));
        r[2][0] = satv(2 * satv(mulq(x, z) - mulq(w, y)));
        r[2][1] = satv(2 * satv(mulq(y, z) + mulq(w, x)));
        r[2][2] = satv(QONE - satv(2 * satv(mulq(x, x) + mulq(y, y))));
        for (int i = 0; i < 3; i++)
            ori_err[i] = satv(mulq(r[i][0], e[0]) + mulq(r[i][1], e[1]) + mulq(r[i][2], e[2]));
    endfunction

    function automatic void predict_pose(pose_req_t req);
        longint v[7];
        wrench_t exp_w;
        longint k, b, err;
        for (int i = 0; i < 7; i++) v[i] = longint'($signed(req.f[i]));
        case (req.op)
            OP_TARGET: begin
                for (int i = 0; i < 3; i++) tgt_pos[i] = v[i];
                for (int i = 0; i < 4; i++) tgt_q[i] = v[i + 3];
            end
            OP_CURRENT: begin
                for (int i = 0; i < 3; i++) cur_pos[i] = v[i];
                form_orient_error(v[3], v[4], v[5], v[6]);
            end
            OP_TWIST: begin
                for (int i = 0; i < 6; i++) begin
                    if (i < 3) begin
                        k = gain[REG_STIFF_LIN];
                        err = satv(tgt_pos[i] - cur_pos[i]);
                        b = (i == 2) ? gain[REG_DAMP_LZ] : gain[REG_DAMP_LXY];
                    end else begin
                        k = gain[REG_STIFF_ANG];
                        err = ori_err[i - 3];
                        b = (i == 5) ? gain[REG_DAMP_AZ] : gain[REG_DAMP_AXY];
                    end
                    exp_w.w[i] = VW'(satv(k * err - b * v[i]));
                end
                expected_wrenches.push_back(exp_w);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        pose_req_t req;
        if (!i_rst_n) begin
            pose_bus.valid <= 1'b0;
            send_gap = 0;
        end else if (!pose_bus.valid || pose_bus.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                pose_bus.valid <= 1'b0;
            end else if (pending_poses.size() != 0) begin
                req = pending_poses.pop_front();
                pose_bus.op    <= req.op;
                pose_bus.val_x <= req.f[0];
                pose_bus.val_y <= req.f[1];
                pose_bus.val_z <= req.f[2];
                pose_bus.rot_x <= req.f[3];
                pose_bus.rot_y <= req.f[4];
                pose_bus.rot_z <= req.f[5];
                pose_bus.rot_w <= req.f[6];
                pose_bus.valid <= 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 10);
            end else begin
                pose_bus.valid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_stall = 0;
    always @(posedge i_clk) begin
        pose_req_t acc;
        wrench_t want;
        logic [VW-1:0] got[6];
        string names[6];
        names = '{"force_x", "force_y", "force_z", "torque_x", "torque_y", "torque_z"};
        if (!i_rst_n) begin
            wrench_bus.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (pose_bus.valid && pose_bus.ready) begin
                acc.op = pose_bus.op;
                acc.f = '{pose_bus.val_x, pose_bus.val_y, pose_bus.val_z,
                          pose_bus.rot_x, pose_bus.rot_y, pose_bus.rot_z, pose_bus.rot_w};
                predict_pose(acc);
            end
            if (wrench_bus.valid && wrench_bus.ready) begin
                got = '{wrench_bus.force_x, wrench_bus.force_y, wrench_bus.force_z,
                        wrench_bus.torque_x, wrench_bus.torque_y, wrench_bus.torque_z};
                if (expected_wrenches.size() == 0) begin
                    $display("unexpected wrench at %0t", $realtime);
                    mismatches++;
                end else begin
                    want = expected_wrenches.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (got[i] !== want.w[i]) report_mismatch(names[i], got[i], want.w[i]);
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                wrench_bus.ready <= 1'b0;
            end else begin
                wrench_bus.ready <= 1'b1;
            end
        end
    end

    task automatic write_gain(logic [CIDX_W-1:0] idx, logic [CW-1:0] data);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx <= REG_DAMP_AZ) gain[idx] = data;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic push_req(logic [OP_W-1:0] op, logic [VW-1:0] a, logic [VW-1:0] b,
                            logic [VW-1:0] c, logic [VW-1:0] d, logic [VW-1:0] e,
                            logic [VW-1:0] f, logic [VW-1:0] g);
        pose_req_t req;
        req.op = op;
        req.f = '{a, b, c, d, e, f, g};
        pending_poses.push_back(req);
    endtask

    task automatic wait_idle();
        while (pending_poses.size() != 0 || pose_bus.valid || expected_wrenches.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [VW-1:0] rand_pos();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return VW'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    // unit quaternion; sometimes with w forced to zero for the half-turn case
    task automatic rand_unit_quat(logic [OP_W-1:0] op);
        real c[4];
        real n;
        logic [VW-1:0] q[4];
        for (int i = 0; i < 4; i++) c[i] = (real'($urandom_range(0, 2000000)) - 1.0e6) / 1.0e6;
        if ($urandom_range(0, 3) == 0) c[3] = 0.0;
        n = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3]);
        if (n < 1.0e-3) begin
            c = '{0.0, 0.0, 0.0, 1.0};
            n = 1.0;
        end
        for (int i = 0; i < 4; i++) q[i] = VW'($rtoi(c[i] / n * 65536.0));
        push_req(op, rand_pos(), rand_pos(), rand_pos(), q[0], q[1], q[2], q[3]);
    endtask

    function automatic logic [VW-1:0] rand_rate();
        if ($urandom_range(0, 5) == 0) return $urandom;
        return VW'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endfunction

    task automatic random_phase(int n_items);
        int r;
        while (pending_poses.size() < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                rand_unit_quat(OP_TARGET);
                rand_unit_quat(OP_CURRENT);
                repeat ($urandom_range(1, 3))
                    push_req(OP_TWIST, rand_rate(), rand_rate(), rand_rate(),
                             rand_rate(), rand_rate(), rand_rate(), $urandom);
            end else if (r == 7) begin
                push_req(OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            end else if (r == 8) begin
                push_req(OP_CURRENT, rand_pos(), rand_pos(), rand_pos(), rand_rate(),
                         rand_rate(), rand_rate(), rand_rate());
            end else begin
                push_req(OP_TWIST, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
            end
        end
    endtask

    task automatic write_all_gains(logic [CW-1:0] g0, logic [CW-1:0] g1, logic [CW-1:0] g2,
                                   logic [CW-1:0] g3, logic [CW-1:0] g4, logic [CW-1:0] g5);
        write_gain(REG_STIFF_LIN, g0);
        write_gain(REG_STIFF_ANG, g1);
        write_gain(REG_DAMP_LXY, g2);
        write_gain(REG_DAMP_LZ, g3);
        write_gain(REG_DAMP_AXY, g4);
        write_gain(REG_DAMP_AZ, g5);
        write_gain($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CW'($urandom));
    endtask

    initial begin
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        pose_bus.valid = 1'b0;
        pose_bus.op = '0;
        pose_bus.val_x = '0; pose_bus.val_y = '0; pose_bus.val_z = '0;
        pose_bus.rot_x = '0; pose_bus.rot_y = '0; pose_bus.rot_z = '0; pose_bus.rot_w = '0;
        wrench_bus.ready = 1'b0;
        gain = '{100, 150, 90, 60, 90, 60};
        tgt_pos = '{0, 0, 0};
        cur_pos = '{0, 0, 0};
        ori_err = '{0, 0, 0};
        tgt_q = '{0, 0, 0, QONE};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        // directed, reset gains
        push_req(OP_TWIST, 0, 0, 0, 0, 0, 0, 0);
        push_req(OP_TWIST, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_req(OP_TWIST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_req(OP_TARGET, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 32'h0001_0000);
        push_req(OP_CURRENT, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
        push_req(OP_TWIST, 32'h0000_8000, 32'hffff_8000, 32'h0000_0001, 32'h0000_4000,
                 32'hffff_c000, 32'h0001_0000, 0);
        push_req(OP_TARGET, 0, 0, 0, 0, 0, 32'd46341, 32'd46341);
        // negative w: flipped on the scalar part
        push_req(OP_CURRENT, 32'h0000_1000, 0, 0, 0, 0, 0, 32'hffff_0000);
        push_req(OP_TWIST, 0, 0, 0, 0, 0, 0, 0);
        push_req(OP_TARGET, 0, 0, 0, 0, 0, 0, 32'h0001_0000);
        // half turn: sign from the largest vector component
        push_req(OP_CURRENT, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
        push_req(OP_TWIST, 0, 0, 0, 0, 0, 0, 0);
        // equal vector magnitudes: lower index decides
        push_req(OP_CURRENT, 0, 0, 0, 32'd46341, 32'd46341, 0, 0);
        push_req(OP_TWIST, 0, 0, 0, 0, 0, 0, 0);
        // non-unit quaternions and saturation
        push_req(OP_CURRENT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_req(OP_TWIST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 0);
        push_req(OP_TARGET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_req(OP_CURRENT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_req(OP_TWIST, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 0);
        push_req(OP_CURRENT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0,
                 32'h0001_0000);
        push_req(OP_TWIST, 0, 0, 0, 0, 0, 0, 0);
        // undefined op leaves state alone
        push_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
        push_req(OP_TWIST, 32'h0000_0100, 0, 0, 0, 0, 0, 0);
        wait_idle();

        random_phase(330);
        wait_idle();

        write_all_gains(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        no_idle = 1'b1;
        random_phase(330);
        wait_idle();
        no_idle = 1'b0;

        write_all_gains(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        random_phase(330);
        wait_idle();

        write_all_gains(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                        CW'($urandom), CW'($urandom));
        random_phase(330);
        wait_idle();

        write_all_gains(10'd1023, 10'd0, 10'd1, 10'd1023, 10'd0, 10'd512);
        random_phase(330);
        wait_idle();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/cif_pkg.sv
rtl/cif_if.sv
rtl/cartesian_impedance_force_unit.sv
verif/tb_cartesian_impedance_force_unit.sv
